### hw/rtl/cwps_pkg.sv
package cwps_pkg;

   // Geometry of one cube face and field widths.
   localparam int FACE_SIZE = 8;
   localparam int FACE_W    = 3;
   localparam int COORD_W   = 3;
   localparam int TIME_W    = 16;
   localparam int FREQ_W    = 12;
   localparam int DIST_W    = 13;
   localparam int COLOR_W   = 8;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   // Pipeline depth and the first stage of each section.
   localparam int NUM_STAGES  = 8;
   localparam int STG_DIST    = 0;
   localparam int STG_PHASE   = 1;
   localparam int STG_COLOR   = 3;

   // Face codes that take part in the mirrored pairing.
   localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_CENTER_FACE    = 2'd0;
   localparam logic [1:0] REG_CENTER_COL     = 2'd1;
   localparam logic [1:0] REG_CENTER_ROW     = 2'd2;
   localparam logic [1:0] REG_WAVE_FREQUENCY = 2'd3;

   // Register reset values.
   localparam logic [FACE_W-1:0]  RST_CENTER_FACE    = 3'd0;
   localparam logic [COORD_W-1:0] RST_CENTER_COL     = 3'd4;
   localparam logic [COORD_W-1:0] RST_CENTER_ROW     = 3'd4;
   localparam logic [FREQ_W-1:0]  RST_WAVE_FREQUENCY = 12'd256;

   // Arithmetic constants. The hue circle is 360 degrees in Q8, which is
   // 45 << 11, and one hue sector is 60 degrees in Q8, which is 15 << 10.
   localparam int HUE_DIST_MUL   = 20;
   localparam int HUE_TIME_MUL   = 50;
   localparam int INV_TWO_PI_Q16 = 10430;
   localparam int HUE_MOD_DIV    = 45;
   localparam int RECIP_45       = 1456;
   localparam int SECTOR_STEP    = 15;
   localparam int RECIP_15       = 4369;
   localparam int HUE_SECTOR     = 15360;

   typedef struct packed {
      logic [FACE_W-1:0]  face;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [FREQ_W-1:0]  freq;
   } cfg_type;

   // Rounded square root of n, scaled by 256, for every sum of two squares
   // of offsets up to 7.
   function automatic logic [DIST_W-1:0] sqrt_q8(input logic [6:0] n);
      logic [DIST_W-1:0] r;
      case (n)
         7'd1:    r = 13'd256;
         7'd2:    r = 13'd362;
         7'd4:    r = 13'd512;
         7'd5:    r = 13'd572;
         7'd8:    r = 13'd724;
         7'd9:    r = 13'd768;
         7'd10:   r = 13'd810;
         7'd13:   r = 13'd923;
         7'd16:   r = 13'd1024;
         7'd17:   r = 13'd1056;
         7'd18:   r = 13'd1086;
         7'd20:   r = 13'd1145;
         7'd25:   r = 13'd1280;
         7'd26:   r = 13'd1305;
         7'd29:   r = 13'd1379;
         7'd32:   r = 13'd1448;
         7'd34:   r = 13'd1493;
         7'd36:   r = 13'd1536;
         7'd37:   r = 13'd1557;
         7'd40:   r = 13'd1619;
         7'd41:   r = 13'd1639;
         7'd45:   r = 13'd1717;
         7'd49:   r = 13'd1792;
         7'd50:   r = 13'd1810;
         7'd52:   r = 13'd1846;
         7'd53:   r = 13'd1864;
         7'd58:   r = 13'd1950;
         7'd61:   r = 13'd1999;
         7'd65:   r = 13'd2064;
         7'd72:   r = 13'd2172;
         7'd74:   r = 13'd2202;
         7'd85:   r = 13'd2360;
         7'd98:   r = 13'd2534;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Quarter wave of round(255 * sin), 65 points.
   function automatic logic [7:0] quarter_sine(input logic [6:0] k);
      logic [7:0] s;
      case (k)
         7'd0:  s = 8'd0;   7'd1:  s = 8'd6;   7'd2:  s = 8'd13;  7'd3:  s = 8'd19;
         7'd4:  s = 8'd25;  7'd5:  s = 8'd31;  7'd6:  s = 8'd37;  7'd7:  s = 8'd44;
         7'd8:  s = 8'd50;  7'd9:  s = 8'd56;  7'd10: s = 8'd62;  7'd11: s = 8'd68;
         7'd12: s = 8'd74;  7'd13: s = 8'd80;  7'd14: s = 8'd86;  7'd15: s = 8'd92;
         7'd16: s = 8'd98;  7'd17: s = 8'd103; 7'd18: s = 8'd109; 7'd19: s = 8'd115;
         7'd20: s = 8'd120; 7'd21: s = 8'd126; 7'd22: s = 8'd131; 7'd23: s = 8'd136;
         7'd24: s = 8'd142; 7'd25: s = 8'd147; 7'd26: s = 8'd152; 7'd27: s = 8'd157;
         7'd28: s = 8'd162; 7'd29: s = 8'd167; 7'd30: s = 8'd171; 7'd31: s = 8'd176;
         7'd32: s = 8'd180; 7'd33: s = 8'd185; 7'd34: s = 8'd189; 7'd35: s = 8'd193;
         7'd36: s = 8'd197; 7'd37: s = 8'd201; 7'd38: s = 8'd205; 7'd39: s = 8'd208;
         7'd40: s = 8'd212; 7'd41: s = 8'd215; 7'd42: s = 8'd219; 7'd43: s = 8'd222;
         7'd44: s = 8'd225; 7'd45: s = 8'd228; 7'd46: s = 8'd231; 7'd47: s = 8'd233;
         7'd48: s = 8'd236; 7'd49: s = 8'd238; 7'd50: s = 8'd240; 7'd51: s = 8'd242;
         7'd52: s = 8'd244; 7'd53: s = 8'd246; 7'd54: s = 8'd247; 7'd55: s = 8'd249;
         7'd56: s = 8'd250; 7'd57: s = 8'd251; 7'd58: s = 8'd252; 7'd59: s = 8'd253;
         7'd60: s = 8'd254; 7'd61: s = 8'd254; 7'd62: s = 8'd255; 7'd63: s = 8'd255;
         7'd64: s = 8'd255;
         default: s = 8'd0;
      endcase
      return s;
   endfunction

endpackage

### hw/rtl/cwps_csr.sv
module cwps_csr
   import cwps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[ADDR_W-1:2];

   // Register writes, one register per word address.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CENTER_FACE:    cfg_in.face = pwdata[FACE_W-1:0];
            REG_CENTER_COL:     cfg_in.col  = pwdata[COORD_W-1:0];
            REG_CENTER_ROW:     cfg_in.row  = pwdata[COORD_W-1:0];
            REG_WAVE_FREQUENCY: cfg_in.freq = pwdata[FREQ_W-1:0];
            default:            cfg_in      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.face <= RST_CENTER_FACE;
         cfg_ff.col  <= RST_CENTER_COL;
         cfg_ff.row  <= RST_CENTER_ROW;
         cfg_ff.freq <= RST_WAVE_FREQUENCY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data.
   always_comb begin
      case (reg_idx)
         REG_CENTER_FACE:    prdata = DATA_W'(cfg_ff.face);
         REG_CENTER_COL:     prdata = DATA_W'(cfg_ff.col);
         REG_CENTER_ROW:     prdata = DATA_W'(cfg_ff.row);
         REG_WAVE_FREQUENCY: prdata = DATA_W'(cfg_ff.freq);
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/cwps_dist.sv
module cwps_dist
   import cwps_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [FACE_W-1:0]  pixel_face,
   input  logic [COORD_W-1:0] pixel_col,
   input  logic [COORD_W-1:0] pixel_row,
   input  logic [TIME_W-1:0]  wave_time,
   input  cfg_type            cfg,
   output logic [DIST_W-1:0]  distance,
   output logic [TIME_W-1:0]  dist_time
);

   localparam int SUM_W = 5;

   logic [COORD_W-1:0]      dx, dy;
   logic [6:0]              sq_sum;
   logic signed [SUM_W-1:0] mirror_diff;
   logic [SUM_W-1:0]        mirror_abs;
   logic [SUM_W-1:0]        hop_sum;
   logic                    same_face, paired;
   logic [DIST_W-1:0]       dist_in, dist_ff;
   logic [TIME_W-1:0]       time_ff;

   // Offsets from the wave center on the pixel's face.
   assign dx = (pixel_col >= cfg.col) ? pixel_col - cfg.col : cfg.col - pixel_col;
   assign dy = (pixel_row >= cfg.row) ? pixel_row - cfg.row : cfg.row - pixel_row;
   assign sq_sum = 7'(dx * dx) + 7'(dy * dy);

   // The front face is seen mirrored from the top and bottom faces.
   assign mirror_diff = SUM_W'(FACE_SIZE - 1) - SUM_W'(cfg.col) - SUM_W'(pixel_col);
   assign mirror_abs  = mirror_diff[SUM_W-1] ? SUM_W'(-mirror_diff) : SUM_W'(mirror_diff);

   assign same_face = (pixel_face == cfg.face);
   assign paired    = ((pixel_face == FACE_FRONT) &&
                       ((cfg.face == FACE_TOP) || (cfg.face == FACE_BOTTOM))) ||
                      (((pixel_face == FACE_TOP) || (pixel_face == FACE_BOTTOM)) &&
                       (cfg.face == FACE_FRONT));

   // Whole-pixel hop count across faces, by pairing.
   always_comb begin
      if (paired) begin
         hop_sum = SUM_W'(FACE_SIZE / 2) + mirror_abs + SUM_W'(dy);
      end else begin
         hop_sum = SUM_W'(FACE_SIZE) + SUM_W'(dx) + SUM_W'(dy);
      end
   end

   // Euclidean distance on the center's face, else the hop count in Q5.8.
   assign dist_in = same_face ? sqrt_q8(sq_sum) : {hop_sum, 8'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
         time_ff <= wave_time;
      end
   end

   assign distance  = dist_ff;
   assign dist_time = time_ff;

endmodule

### hw/rtl/cwps_phase.sv
module cwps_phase
   import cwps_pkg::*;
(
   input  logic              clock,
   input  logic [1:0]        en,
   input  logic [DIST_W-1:0] distance,
   input  logic [TIME_W-1:0] dist_time,
   input  logic [FREQ_W-1:0] freq,
   output logic [7:0]        sine_idx,
   output logic [10:0]       hue_hi,
   output logic [5:0]        hue_quot,
   output logic [10:0]       hue_lo
);

   localparam int PROD_W  = DIST_W + FREQ_W;
   localparam int PHASE_W = PROD_W - 8 + 1;
   localparam int HUE_W   = 22;
   localparam int ANGLE_W = 24;

   logic [PROD_W-1:0]         prod;
   logic [PROD_W-9:0]         prod_hi_in, prod_hi_ff;
   logic [HUE_W-1:0]          hue_lin_in, hue_lin_ff;
   logic [TIME_W-1:0]         time_ff;
   logic signed [PHASE_W-1:0] phase;
   logic [ANGLE_W-1:0]        angle;
   logic [21:0]               quot_prod;
   logic [7:0]                idx_in, idx_ff;
   logic [10:0]               hi_in, hi_ff;
   logic [5:0]                quot_in, quot_ff;
   logic [10:0]               lo_ff;

   // Stage one: distance times frequency, and the linear hue term.
   assign prod       = PROD_W'(distance) * PROD_W'(freq);
   assign prod_hi_in = prod[PROD_W-1:8];
   assign hue_lin_in = HUE_W'(distance) * HUE_W'(HUE_DIST_MUL) +
                       HUE_W'(dist_time) * HUE_W'(HUE_TIME_MUL);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_hi_ff <= prod_hi_in;
         hue_lin_ff <= hue_lin_in;
         time_ff    <= dist_time;
      end
   end

   // Stage two: phase to a 256-step angle, and the quotient estimate of the
   // upper hue bits over 45.
   assign phase  = $signed({1'b0, prod_hi_ff}) - $signed(PHASE_W'(time_ff));
   assign angle  = ANGLE_W'({{(ANGLE_W-PHASE_W){phase[PHASE_W-1]}}, phase} *
                            ANGLE_W'(INV_TWO_PI_Q16));
   assign idx_in = angle[ANGLE_W-1:ANGLE_W-8];

   assign hi_in     = hue_lin_ff[HUE_W-1:11];
   assign quot_prod = 22'(hi_in) * 22'(RECIP_45);
   assign quot_in   = quot_prod[21:16];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         idx_ff  <= idx_in;
         hi_ff   <= hi_in;
         quot_ff <= quot_in;
         lo_ff   <= hue_lin_ff[10:0];
      end
   end

   assign sine_idx = idx_ff;
   assign hue_hi   = hi_ff;
   assign hue_quot = quot_ff;
   assign hue_lo   = lo_ff;

endmodule

### hw/rtl/cwps_color.sv
module cwps_color
   import cwps_pkg::*;
(
   input  logic               clock,
   input  logic [4:0]         en,
   input  logic [7:0]         sine_idx,
   input  logic [10:0]        hue_hi,
   input  logic [5:0]         hue_quot,
   input  logic [10:0]        hue_lo,
   output logic [COLOR_W-1:0] red,
   output logic [COLOR_W-1:0] green,
   output logic [COLOR_W-1:0] blue
);

   // Hue sectors of 60 degrees each.
   localparam logic [2:0] SEC_RED_TO_YELLOW    = 3'd0;
   localparam logic [2:0] SEC_YELLOW_TO_GREEN  = 3'd1;
   localparam logic [2:0] SEC_GREEN_TO_CYAN    = 3'd2;
   localparam logic [2:0] SEC_CYAN_TO_BLUE     = 3'd3;
   localparam logic [2:0] SEC_BLUE_TO_MAGENTA  = 3'd4;
   localparam logic [2:0] SEC_MAGENTA_TO_RED   = 3'd5;
   localparam int         NUM_SECTORS          = 6;

   // Stage three signals.
   logic [10:0] rem45_raw;
   logic [5:0]  rem45;
   logic [7:0]  qs;
   logic [8:0]  bright_sum;
   logic [7:0]  bright3_in, bright3_ff;
   logic [16:0] hue3_in, hue3_ff;

   // Stage four signals.
   logic [6:0]  h10;
   logic [2:0]  sector4_in, sector4_ff;
   logic [6:0]  base;
   logic [3:0]  rem15;
   logic [13:0] frac_raw;
   logic [13:0] frac4_in, frac4_ff;
   logic [7:0]  bright4_ff;

   // Stage five to seven signals.
   logic [21:0] mid_prod;
   logic [11:0] z5_ff, z6_ff;
   logic [2:0]  sector5_ff, sector6_ff;
   logic [7:0]  bright5_ff, bright6_ff;
   logic [23:0] q_prod;
   logic [7:0]  q6_ff;
   logic [11:0] rem_mid;
   logic [7:0]  mid;
   logic [COLOR_W-1:0] red_in, green_in, blue_in;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;

   // Stage three: finish the hue modulo 360 degrees; look up brightness.
   assign rem45_raw = hue_hi - 11'(hue_quot * 6'(HUE_MOD_DIV));
   assign rem45     = (rem45_raw >= 11'(HUE_MOD_DIV)) ?
                      6'(rem45_raw - 11'(HUE_MOD_DIV)) : rem45_raw[5:0];
   assign hue3_in   = {rem45, hue_lo};

   assign qs = sine_idx[6] ? quarter_sine(7'd64 - {1'b0, sine_idx[5:0]})
                           : quarter_sine({1'b0, sine_idx[5:0]});
   assign bright_sum = sine_idx[7] ? 9'(9'd256 - {1'b0, qs}) : 9'(9'd256 + {1'b0, qs});
   assign bright3_in = bright_sum[8:1];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         bright3_ff <= bright3_in;
         hue3_ff    <= hue3_in;
      end
   end

   // Stage four: sector and fraction within the sector.
   assign h10 = hue3_ff[16:10];

   always_comb begin
      sector4_in = SEC_RED_TO_YELLOW;
      base       = '0;
      for (int s = 1; s < NUM_SECTORS; s++) begin
         if (h10 >= 7'(s * SECTOR_STEP)) begin
            sector4_in = 3'(s);
            base       = 7'(s * SECTOR_STEP);
         end
      end
   end

   assign rem15    = 4'(h10 - base);
   assign frac_raw = {rem15, hue3_ff[9:0]};
   assign frac4_in = sector4_in[0] ? 14'(14'(HUE_SECTOR) - frac_raw) : frac_raw;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sector4_ff <= sector4_in;
         frac4_ff   <= frac4_in;
         bright4_ff <= bright3_ff;
      end
   end

   // Stage five: brightness times fraction, pre-shifted by 1024.
   assign mid_prod = 22'(bright4_ff) * 22'(frac4_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         z5_ff      <= mid_prod[21:10];
         sector5_ff <= sector4_ff;
         bright5_ff <= bright4_ff;
      end
   end

   // Stage six: quotient estimate over 15 by reciprocal.
   assign q_prod = 24'(z5_ff) * 24'(RECIP_15);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         q6_ff      <= q_prod[23:16];
         z6_ff      <= z5_ff;
         sector6_ff <= sector5_ff;
         bright6_ff <= bright5_ff;
      end
   end

   // Stage seven: correct the quotient and place the channels.
   assign rem_mid = z6_ff - 12'(q6_ff * 4'(SECTOR_STEP));
   assign mid     = (rem_mid >= 12'(SECTOR_STEP)) ? 8'(q6_ff + 8'd1) : q6_ff;

   always_comb begin
      case (sector6_ff)
         SEC_RED_TO_YELLOW: begin
            red_in = bright6_ff; green_in = mid;        blue_in = '0;
         end
         SEC_YELLOW_TO_GREEN: begin
            red_in = mid;        green_in = bright6_ff; blue_in = '0;
         end
         SEC_GREEN_TO_CYAN: begin
            red_in = '0;         green_in = bright6_ff; blue_in = mid;
         end
         SEC_CYAN_TO_BLUE: begin
            red_in = '0;         green_in = mid;        blue_in = bright6_ff;
         end
         SEC_BLUE_TO_MAGENTA: begin
            red_in = mid;        green_in = '0;         blue_in = bright6_ff;
         end
         SEC_MAGENTA_TO_RED: begin
            red_in = bright6_ff; green_in = '0;         blue_in = mid;
         end
         default: begin
            red_in = bright6_ff; green_in = '0;         blue_in = mid;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

### hw/rtl/cube_wave_pixel_shader.sv
// Pixel shader for a wave spreading over the faces of a cube.
//
// Request channel (req_): one beat per pixel with face, column, row and the
// animation time. Response channel (rsp_): one beat per request with the red,
// green and blue intensities, in request order. A beat moves when valid is
// high and stall is low.
// The APB port sets the wave center (face, column, row) and the spatial
// frequency; write it only while no pixel is in flight.
//
// The datapath is an 8-stage pipeline: distance, phase product, angle and hue
// reduction, sine and hue modulo, hue sector and fraction, brightness product,
// quotient estimate and color output register. One pixel enters every cycle
// unless req_stall is high. When the receiver stalls, stages holding a beat
// freeze while empty stages in front of them keep filling, so req_stall rises
// only once all eight stages hold a beat. Reset empties the pipeline and loads
// the register defaults: center on face 0 at column 4, row 4, frequency 1.0.
module cube_wave_pixel_shader
   import cwps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FACE_W-1:0]  req_pixel_face,
   input  logic [COORD_W-1:0] req_pixel_col,
   input  logic [COORD_W-1:0] req_pixel_row,
   input  logic [TIME_W-1:0]  req_wave_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COLOR_W-1:0] rsp_red,
   output logic [COLOR_W-1:0] rsp_green,
   output logic [COLOR_W-1:0] rsp_blue,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   cfg_type                 cfg;
   logic [NUM_STAGES-1:0]   vld_ff, vld_in, en;
   logic [DIST_W-1:0]       distance;
   logic [TIME_W-1:0]       dist_time;
   logic [7:0]              sine_idx;
   logic [10:0]             hue_hi;
   logic [5:0]              hue_quot;
   logic [10:0]             hue_lo;
   logic                    req_acc, rsp_take;

   assign pready = 1'b1;

   cwps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   // Valid bits travel with the data.
   always_comb begin
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign req_acc   = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   cwps_dist u_dist (
      .clock      (clock),
      .en         (en[STG_DIST]),
      .pixel_face (req_pixel_face),
      .pixel_col  (req_pixel_col),
      .pixel_row  (req_pixel_row),
      .wave_time  (req_wave_time),
      .cfg        (cfg),
      .distance   (distance),
      .dist_time  (dist_time)
   );

   cwps_phase u_phase (
      .clock     (clock),
      .en        (en[STG_COLOR-1:STG_PHASE]),
      .distance  (distance),
      .dist_time (dist_time),
      .freq      (cfg.freq),
      .sine_idx  (sine_idx),
      .hue_hi    (hue_hi),
      .hue_quot  (hue_quot),
      .hue_lo    (hue_lo)
   );

   cwps_color u_color (
      .clock    (clock),
      .en       (en[NUM_STAGES-1:STG_COLOR]),
      .sine_idx (sine_idx),
      .hue_hi   (hue_hi),
      .hue_quot (hue_quot),
      .hue_lo   (hue_lo),
      .red      (rsp_red),
      .green    (rsp_green),
      .blue     (rsp_blue)
   );

   // The input side stalls only when every stage holds a beat.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("request stalled while the pipeline has an empty stage");

   // A beat taken in without one leaving adds exactly one beat in flight.
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !rsp_take) |=> ($countones(vld_ff) == $past($countones(vld_ff)) + 1))
      else $error("beat lost or duplicated on entry");

   // A beat leaving without one taken in removes exactly one beat in flight.
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !req_acc) |=> ($countones(vld_ff) == $past($countones(vld_ff)) - 1))
      else $error("beat lost or duplicated on exit");

   // Full saturation leaves one channel dark in every color.
   a_one_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_red == '0) || (rsp_green == '0) || (rsp_blue == '0)))
      else $error("response color has no zero channel");

endmodule
